/* hdl/min_max_normalizer_core_macros.svh */
// Assertion macros for the min-max normalizer core.
// Included by the top level only; no other dependencies.
`ifndef MIN_MAX_NORMALIZER_CORE_MACROS_SVH
`define MIN_MAX_NORMALIZER_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MMN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/mmn_pkg.sv */
// Shared types and constants of the min-max normalizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mmn_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_COLS    = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // configuration port
  localparam int DIM_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int TOT_W     = 2 * DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Q1.16 quotient
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W    = FRAC_BITS + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FLAT       = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

  // control part of a queued fetch job
  typedef struct packed {
    status_t status;
    logic    last;
  } job_ctrl_t;

  localparam int JOB_CTRL_W = $bits(job_ctrl_t);

endpackage

/* hdl/min_max_normalizer_core.sv */
// Min-max normalizer core. A load is taken when start is seen with busy low; loads may
// follow every cycle while busy is low. A fetch goes through the store read, the queue
// and the result register, an ok one also through the 17-step radix-2 divider, which
// takes one job at a time. busy covers the store read and a full queue.
// Synchronous active-low reset: 1x1 matrix, empty, min/max zero; store contents kept.
// Depends on mmn_pkg, mmn_front, mmn_queue, mmn_divider and the macros header.
`timescale 1ns / 1ps
`include "min_max_normalizer_core_macros.svh"

module min_max_normalizer_core #(
  parameter int MAX_ROWS    = mmn_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = mmn_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = mmn_pkg::DEF_SAMPLE_BITS,
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic                           cfg_we,
  input  logic [mmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmn_pkg::DIM_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic [mmn_pkg::QUOT_W-1:0]     out_normalized,
  output logic [ROW_W-1:0]               out_row_index,
  output logic [COL_W-1:0]               out_col_index,
  output mmn_pkg::status_t               out_status,
  output logic                           out_last_element
);
  import mmn_pkg::*;

  localparam int Q_WIDTH = JOB_CTRL_W + 2 * SAMPLE_BITS + ROW_W + COL_W;

  logic                    push_w;
  job_ctrl_t               push_ctrl_w;
  logic [SAMPLE_BITS-1:0]  push_num_w;
  logic [SAMPLE_BITS-1:0]  push_den_w;
  logic [ROW_W-1:0]        push_row_w;
  logic [COL_W-1:0]        push_col_w;
  logic [Q_WIDTH-1:0]      q_wdata_w;
  logic [Q_WIDTH-1:0]      q_rdata_w;
  logic                    q_full_w;
  logic                    q_empty_w;
  logic                    pop_w;
  job_ctrl_t               head_ctrl_w;
  logic [SAMPLE_BITS-1:0]  head_num_w;
  logic [SAMPLE_BITS-1:0]  head_den_w;
  logic [ROW_W-1:0]        head_row_w;
  logic [COL_W-1:0]        head_col_w;

  // front: config, store, min/max, fetch order
  mmn_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ROW_W       (ROW_W),
    .COL_W       (COL_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .op_i        (in_operation),
    .sample_i    (in_sample),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .q_full_i    (q_full_w),
    .push_o      (push_w),
    .push_ctrl_o (push_ctrl_w),
    .push_num_o  (push_num_w),
    .push_den_o  (push_den_w),
    .push_row_o  (push_row_w),
    .push_col_o  (push_col_w)
  );

  // job word packing
  assign q_wdata_w = {push_ctrl_w, push_num_w, push_den_w, push_row_w, push_col_w};
  assign {head_ctrl_w, head_num_w, head_den_w, head_row_w, head_col_w} = q_rdata_w;

  mmn_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push_w),
    .wdata_i (q_wdata_w),
    .pop_i   (pop_w),
    .rdata_o (q_rdata_w),
    .full_o  (q_full_w),
    .empty_o (q_empty_w)
  );

  // back: divider and result register
  mmn_divider #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ROW_W       (ROW_W),
    .COL_W       (COL_W)
  ) u_divider (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty_i    (q_empty_w),
    .pop_o        (pop_w),
    .job_ctrl_i   (head_ctrl_w),
    .num_i        (head_num_w),
    .den_i        (head_den_w),
    .row_i        (head_row_w),
    .col_i        (head_col_w),
    .out_valid_o  (out_valid),
    .normalized_o (out_normalized),
    .row_o        (out_row_index),
    .col_o        (out_col_index),
    .status_o     (out_status),
    .last_o       (out_last_element)
  );

  // checks
  `MMN_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, push_w, !q_full_w, "job pushed into full queue")
  `MMN_ASSERT_NEXT(a_fetch_holds_busy, clk, rst_n, start && !busy && in_operation == OP_FETCH, busy, "busy low after fetch")
  `MMN_ASSERT_SAME(a_ok_in_range, clk, rst_n, out_valid && out_status == ST_OK, out_normalized <= QUOT_W'(1 << FRAC_BITS), "quotient above one")
  `MMN_ASSERT_SAME(a_no_value_on_error, clk, rst_n, out_valid && out_status != ST_OK, out_normalized == '0, "value given without ok status")

endmodule

/* hdl/mmn_queue.sv */
// Small register FIFO that carries fetch jobs from front to back.
// Depends on mmn_pkg for the default depth.
`timescale 1ns / 1ps

module mmn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mmn_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import mmn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign rdata_o = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop_i)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push_i && !pop_i) count_r <= count_r + CNT_W'(1);
      else if (pop_i && !push_i) count_r <= count_r - CNT_W'(1);
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push_i) slot_r[wr_ptr_r] <= wdata_i;
  end

endmodule

/* hdl/mmn_front.sv */
// Front end: configuration, sample store, running min/max and fetch sequencing.
// Depends on mmn_pkg; feeds fetch jobs into mmn_queue.
`timescale 1ns / 1ps

module mmn_front #(
  parameter int MAX_ROWS    = mmn_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = mmn_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = mmn_pkg::DEF_SAMPLE_BITS,
  parameter int ROW_W       = 5,
  parameter int COL_W       = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              op_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic                              cfg_we_i,
  input  logic [mmn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mmn_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output mmn_pkg::job_ctrl_t                push_ctrl_o,
  output logic [SAMPLE_BITS-1:0]            push_num_o,
  output logic [SAMPLE_BITS-1:0]            push_den_o,
  output logic [ROW_W-1:0]                  push_row_o,
  output logic [COL_W-1:0]                  push_col_o
);
  import mmn_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > TOT_W) ? CNT_W : TOT_W;
  localparam int CW      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'((MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'((MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS);

  typedef enum logic {
    FS_IDLE,
    FS_READ
  } front_state_t;

  front_state_t                   state_r;
  logic [DIM_W-1:0]               rows_r;
  logic [DIM_W-1:0]               cols_r;
  logic [CNT_W-1:0]               loaded_count_r;
  logic [CNT_W-1:0]               fetch_index_r;
  logic [ROW_W-1:0]               fetch_row_r;
  logic [COL_W-1:0]               fetch_col_r;
  logic signed [SAMPLE_BITS-1:0]  smallest_r;
  logic signed [SAMPLE_BITS-1:0]  largest_r;

  // fetch job held while the store read completes
  job_ctrl_t                      pend_ctrl_r;
  logic [SAMPLE_BITS-1:0]         pend_den_r;
  logic signed [SAMPLE_BITS-1:0]  pend_min_r;
  logic [ROW_W-1:0]               pend_row_r;
  logic [COL_W-1:0]               pend_col_r;
  logic signed [SAMPLE_BITS-1:0]  rd_data_r;

  logic [SAMPLE_BITS-1:0]         store_mem [DEPTH];

  logic [TOT_W-1:0]               total_w;
  logic [CNT_W-1:0]               fetch_next_w;
  logic                           full_w;
  logic                           last_w;
  logic                           accept_w;
  logic                           col_wrap_w;
  logic                           load_w;
  logic                           fetch_w;
  logic signed [SAMPLE_BITS:0]    num_diff_w;
  logic signed [SAMPLE_BITS:0]    den_diff_w;

  // 0 counts as 1, larger values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // matrix size and position tests
  assign total_w      = {{DIM_W{1'b0}}, rows_r} * {{DIM_W{1'b0}}, cols_r};
  assign fetch_next_w = fetch_index_r + CNT_W'(1);
  assign full_w       = CMP_W'(loaded_count_r) >= CMP_W'(total_w);
  assign last_w       = CMP_W'(fetch_next_w) >= CMP_W'(total_w);
  assign col_wrap_w   = (CW'(fetch_col_r) + CW'(1)) == CW'(cols_r);

  assign busy_o   = (state_r != FS_IDLE) || q_full_i;
  assign accept_w = start_i && !busy_o;
  assign load_w   = accept_w && (op_i == OP_LOAD) && !full_w;
  assign fetch_w  = accept_w && (op_i == OP_FETCH);

  // spread of the loaded values; never negative
  assign den_diff_w = {largest_r[SAMPLE_BITS-1], largest_r}
                    - {smallest_r[SAMPLE_BITS-1], smallest_r};
  assign num_diff_w = {rd_data_r[SAMPLE_BITS-1], rd_data_r}
                    - {pend_min_r[SAMPLE_BITS-1], pend_min_r};

  // job goes to the queue once the store word is back
  assign push_o      = (state_r == FS_READ);
  assign push_ctrl_o = pend_ctrl_r;
  assign push_num_o  = num_diff_w[SAMPLE_BITS-1:0];
  assign push_den_o  = pend_den_r;
  assign push_row_o  = pend_row_r;
  assign push_col_o  = pend_col_r;

  // control state, configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= FS_IDLE;
      rows_r         <= DIM_W'(1);
      cols_r         <= DIM_W'(1);
      loaded_count_r <= '0;
      fetch_index_r  <= '0;
      fetch_row_r    <= '0;
      fetch_col_r    <= '0;
      smallest_r     <= '0;
      largest_r      <= '0;
    end else begin
      case (state_r)
        FS_IDLE: begin
          if (fetch_w) state_r <= FS_READ;
        end
        FS_READ: begin
          state_r <= FS_IDLE;
        end
        default: begin
          state_r <= FS_IDLE;
        end
      endcase

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROWS: rows_r <= clamp_dim(cfg_data_i, ROWS_LIM);
          REG_COLS: cols_r <= clamp_dim(cfg_data_i, COLS_LIM);
          default: ;
        endcase
        // any register write restarts loading
        loaded_count_r <= '0;
        fetch_index_r  <= '0;
        fetch_row_r    <= '0;
        fetch_col_r    <= '0;
        smallest_r     <= '0;
        largest_r      <= '0;
      end else if (load_w) begin
        loaded_count_r <= loaded_count_r + CNT_W'(1);
        if (loaded_count_r == '0) begin
          smallest_r <= sample_i;
          largest_r  <= sample_i;
        end else if (sample_i < smallest_r) begin
          smallest_r <= sample_i;
        end else if (sample_i > largest_r) begin
          largest_r <= sample_i;
        end
      end else if (fetch_w && full_w) begin
        if (last_w) begin
          // final element: back to loading
          loaded_count_r <= '0;
          fetch_index_r  <= '0;
          fetch_row_r    <= '0;
          fetch_col_r    <= '0;
          smallest_r     <= '0;
          largest_r      <= '0;
        end else begin
          fetch_index_r <= fetch_next_w;
          if (col_wrap_w) begin
            fetch_col_r <= '0;
            fetch_row_r <= fetch_row_r + ROW_W'(1);
          end else begin
            fetch_col_r <= fetch_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  // classify a fetch and capture what the back end needs
  always_ff @(posedge clk) begin
    if (fetch_w) begin
      pend_min_r <= smallest_r;
      pend_den_r <= den_diff_w[SAMPLE_BITS-1:0];
      if (!full_w) begin
        pend_ctrl_r.status <= ST_NOT_LOADED;
        pend_ctrl_r.last   <= 1'b0;
        pend_row_r         <= '0;
        pend_col_r         <= '0;
      end else begin
        pend_ctrl_r.status <= (largest_r == smallest_r) ? ST_FLAT : ST_OK;
        pend_ctrl_r.last   <= last_w;
        pend_row_r         <= fetch_row_r;
        pend_col_r         <= fetch_col_r;
      end
    end
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (load_w) store_mem[loaded_count_r[ADDR_W-1:0]] <= sample_i;
    if (fetch_w) rd_data_r <= store_mem[fetch_index_r[ADDR_W-1:0]];
  end

endmodule

/* hdl/mmn_divider.sv */
// Back end: radix-2 restoring divider producing the Q1.16 result, and result register.
// Depends on mmn_pkg; takes jobs from mmn_queue.
`timescale 1ns / 1ps

module mmn_divider #(
  parameter int SAMPLE_BITS = mmn_pkg::DEF_SAMPLE_BITS,
  parameter int ROW_W       = 5,
  parameter int COL_W       = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty_i,
  output logic                         pop_o,
  input  mmn_pkg::job_ctrl_t           job_ctrl_i,
  input  logic [SAMPLE_BITS-1:0]       num_i,
  input  logic [SAMPLE_BITS-1:0]       den_i,
  input  logic [ROW_W-1:0]             row_i,
  input  logic [COL_W-1:0]             col_i,
  output logic                         out_valid_o,
  output logic [mmn_pkg::QUOT_W-1:0]   normalized_o,
  output logic [ROW_W-1:0]             row_o,
  output logic [COL_W-1:0]             col_o,
  output mmn_pkg::status_t             status_o,
  output logic                         last_o
);
  import mmn_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic {
    BS_IDLE,
    BS_DIV
  } back_state_t;

  back_state_t             state_r;
  logic [STEP_W-1:0]       step_r;
  logic [SAMPLE_BITS:0]    rem_r;
  logic [SAMPLE_BITS-1:0]  den_r;
  logic [QUOT_W-1:0]       quot_r;
  logic [ROW_W-1:0]        row_r;
  logic [COL_W-1:0]        col_r;
  logic                    last_r;

  logic                    out_valid_r;
  logic [QUOT_W-1:0]       out_norm_r;
  logic [ROW_W-1:0]        out_row_r;
  logic [COL_W-1:0]        out_col_r;
  status_t                 out_status_r;
  logic                    out_last_r;

  logic                    ge_w;
  logic [SAMPLE_BITS:0]    diff_w;
  logic [SAMPLE_BITS:0]    rem_sel_w;
  logic [SAMPLE_BITS:0]    rem_nxt;
  logic [QUOT_W-1:0]       quot_nxt;

  // one quotient bit per cycle; remainder stays below twice the divisor
  assign ge_w      = rem_r >= {1'b0, den_r};
  assign diff_w    = rem_r - {1'b0, den_r};
  assign rem_sel_w = ge_w ? diff_w : rem_r;
  assign rem_nxt   = {rem_sel_w[SAMPLE_BITS-1:0], 1'b0};
  assign quot_nxt  = {quot_r[QUOT_W-2:0], ge_w};

  assign pop_o = (state_r == BS_IDLE) && !q_empty_i;

  assign out_valid_o  = out_valid_r;
  assign normalized_o = out_norm_r;
  assign row_o        = out_row_r;
  assign col_o        = out_col_r;
  assign status_o     = out_status_r;
  assign last_o       = out_last_r;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        BS_IDLE: begin
          if (pop_o) begin
            if (job_ctrl_i.status == ST_OK) begin
              state_r <= BS_DIV;
              step_r  <= '0;
              rem_r   <= {1'b0, num_i};
              den_r   <= den_i;
              row_r   <= row_i;
              col_r   <= col_i;
              last_r  <= job_ctrl_i.last;
            end else begin
              // flat or not loaded: no division
              out_valid_r  <= 1'b1;
              out_norm_r   <= '0;
              out_row_r    <= row_i;
              out_col_r    <= col_i;
              out_status_r <= job_ctrl_i.status;
              out_last_r   <= job_ctrl_i.last;
            end
          end
        end
        BS_DIV: begin
          rem_r  <= rem_nxt;
          quot_r <= quot_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(QUOT_W - 1)) begin
            state_r      <= BS_IDLE;
            out_valid_r  <= 1'b1;
            out_norm_r   <= quot_nxt;
            out_row_r    <= row_r;
            out_col_r    <= col_r;
            out_status_r <= ST_OK;
            out_last_r   <= last_r;
          end
        end
        default: begin
          state_r <= BS_IDLE;
        end
      endcase
    end
  end

endmodule
